/* design/sls_pkg.sv */
package sls_pkg;

    localparam int IN_BITS       = 16;
    localparam int OP_BITS       = 5;
    localparam int COUNT_BITS    = 3;
    localparam int TICK_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK          = 5'd0,
        OP_CLICKER_RAISE = 5'd1,
        OP_CLICKER_LOWER = 5'd2,
        OP_CLICKER_STOP  = 5'd3,
        OP_LIFTER_RAISE  = 5'd4,
        OP_LIFTER_LOWER  = 5'd5,
        OP_LIFTER_STOP   = 5'd6,
        OP_INTAKE_RUN    = 5'd7,
        OP_INTAKE_STOP   = 5'd8,
        OP_STOP_ALL      = 5'd9,
        OP_AUTO_START    = 5'd10,
        OP_AUTO_STOP     = 5'd11,
        OP_PAUSE         = 5'd12,
        OP_RESUME        = 5'd13,
        OP_GO            = 5'd14,
        OP_COUNT_INC     = 5'd15,
        OP_COUNT_DEC     = 5'd16,
        OP_ENABLE        = 5'd17,
        OP_DISABLE       = 5'd18
    } op_t;

    typedef enum logic [2:0] {
        CK_TOP    = 3'd0,
        CK_LOWER  = 3'd1,
        CK_BOTTOM = 3'd2,
        CK_HOLD   = 3'd3,
        CK_DELAY  = 3'd4,
        CK_RAISE  = 3'd5
    } clicker_phase_t;

    typedef enum logic [2:0] {
        LF_BOTTOM = 3'd0,
        LF_RAISE  = 3'd1,
        LF_WAIT   = 3'd2,
        LF_TOP    = 3'd3,
        LF_LOWER  = 3'd4
    } lifter_phase_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CLICKER_RAISE = 3'd0,
        CFG_CLICKER_LOWER = 3'd1,
        CFG_CLICKER_HOLD  = 3'd2,
        CFG_LIFTER_RAISE  = 3'd3,
        CFG_LIFTER_LOWER  = 3'd4,
        CFG_INTAKE_RUN    = 3'd5,
        CFG_SAFETY_TICKS  = 3'd6,
        CFG_RESTART_TICKS = 3'd7
    } cfg_index_t;

    // sensor sample carried with every request, lowest bit first: beam .. lifter_at_top
    typedef struct packed {
        logic lifter_at_top;
        logic lifter_at_bottom;
        logic clicker_at_top;
        logic clicker_at_bottom;
        logic beam_blocked;
    } sensors_t;

    // status part of a result, item_count in the lowest bits
    typedef struct packed {
        logic                  safety_stopped;
        logic [2:0]            lifter_phase;
        logic [2:0]            clicker_phase;
        logic                  auto_paused;
        logic                  auto_active;
        logic [COUNT_BITS-1:0] item_count;
    } status_t;

    localparam int STATUS_BITS = $bits(status_t);

endpackage

/* design/sls_cfg_regs.sv */
module sls_cfg_regs
    import sls_pkg::*;
#(
    parameter int DRIVE_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       cfg_data,
    output logic signed [DRIVE_BITS-1:0]   clicker_raise_drive,
    output logic signed [DRIVE_BITS-1:0]   clicker_lower_drive,
    output logic signed [DRIVE_BITS-1:0]   clicker_hold_drive,
    output logic signed [DRIVE_BITS-1:0]   lifter_raise_drive,
    output logic signed [DRIVE_BITS-1:0]   lifter_lower_drive,
    output logic signed [DRIVE_BITS-1:0]   intake_run_drive,
    output logic [TICK_BITS-1:0]           safety_timeout_ticks,
    output logic [TICK_BITS-1:0]           restart_delay_ticks
);

    logic signed [DRIVE_BITS-1:0] ck_raise_reg, ck_lower_reg, ck_hold_reg;
    logic signed [DRIVE_BITS-1:0] lf_raise_reg, lf_lower_reg, in_run_reg;
    logic [TICK_BITS-1:0]         safety_reg, restart_reg;
    logic [DRIVE_BITS-1:0]        drive_data;
    logic                         wr;

    assign cfg_ready  = 1'b1;
    assign wr         = cfg_valid && cfg_ready;
    assign drive_data = cfg_data[DRIVE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ck_raise_reg <= DRIVE_BITS'(1024);
            ck_lower_reg <= DRIVE_BITS'(-1024);
            ck_hold_reg  <= DRIVE_BITS'(200);
            lf_raise_reg <= DRIVE_BITS'(-1024);
            lf_lower_reg <= DRIVE_BITS'(1024);
            in_run_reg   <= DRIVE_BITS'(-1024);
            safety_reg   <= TICK_BITS'(1500);
            restart_reg  <= TICK_BITS'(125);
        end else if (wr) begin
            case (cfg_index_t'(cfg_index))
                CFG_CLICKER_RAISE: ck_raise_reg <= drive_data;
                CFG_CLICKER_LOWER: ck_lower_reg <= drive_data;
                CFG_CLICKER_HOLD:  ck_hold_reg  <= drive_data;
                CFG_LIFTER_RAISE:  lf_raise_reg <= drive_data;
                CFG_LIFTER_LOWER:  lf_lower_reg <= drive_data;
                CFG_INTAKE_RUN:    in_run_reg   <= drive_data;
                CFG_SAFETY_TICKS:  safety_reg   <= cfg_data[TICK_BITS-1:0];
                CFG_RESTART_TICKS: restart_reg  <= cfg_data[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign clicker_raise_drive  = ck_raise_reg;
    assign clicker_lower_drive  = ck_lower_reg;
    assign clicker_hold_drive   = ck_hold_reg;
    assign lifter_raise_drive   = lf_raise_reg;
    assign lifter_lower_drive   = lf_lower_reg;
    assign intake_run_drive     = in_run_reg;
    assign safety_timeout_ticks = safety_reg;
    assign restart_delay_ticks  = restart_reg;

endmodule

/* design/sls_core.sv */
module sls_core
    import sls_pkg::*;
#(
    parameter int DRIVE_BITS = 12,
    parameter int FULL_STACK = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [OP_BITS-1:0]            operation,
    input  sensors_t                      sensors,
    input  logic signed [DRIVE_BITS-1:0]  clicker_raise_drive,
    input  logic signed [DRIVE_BITS-1:0]  clicker_lower_drive,
    input  logic signed [DRIVE_BITS-1:0]  clicker_hold_drive,
    input  logic signed [DRIVE_BITS-1:0]  lifter_raise_drive,
    input  logic signed [DRIVE_BITS-1:0]  lifter_lower_drive,
    input  logic signed [DRIVE_BITS-1:0]  intake_run_drive,
    input  logic [TICK_BITS-1:0]          safety_timeout_ticks,
    input  logic [TICK_BITS-1:0]          restart_delay_ticks,
    output logic signed [DRIVE_BITS-1:0]  clicker_drive_next,
    output logic signed [DRIVE_BITS-1:0]  lifter_drive_next,
    output logic signed [DRIVE_BITS-1:0]  intake_drive_next,
    output status_t                       status_next
);

    localparam logic [COUNT_BITS-1:0] FULL   = COUNT_BITS'(FULL_STACK);
    localparam logic [COUNT_BITS-1:0] FULL_1 = COUNT_BITS'(FULL_STACK + 1);

    clicker_phase_t ck_reg, ck_next;
    lifter_phase_t  lf_reg, lf_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic auto_reg, auto_next, pause_reg, pause_next, go_reg, go_next;
    logic signed [DRIVE_BITS-1:0] ck_drv_reg, ck_drv_next;
    logic signed [DRIVE_BITS-1:0] lf_drv_reg, lf_drv_next;
    logic signed [DRIVE_BITS-1:0] in_drv_reg, in_drv_next;
    logic signed [DRIVE_BITS-1:0] ck_save_reg, ck_save_next;
    logic signed [DRIVE_BITS-1:0] lf_save_reg, lf_save_next;
    logic [TICK_BITS-1:0] safety_reg, safety_next, delay_reg, delay_next;
    logic tripped;
    logic running;

    assign running = auto_reg && !pause_reg;

    // one request: the clicker machine goes first, the lifter sees its updates
    always_comb begin
        ck_next      = ck_reg;
        lf_next      = lf_reg;
        count_next   = count_reg;
        auto_next    = auto_reg;
        pause_next   = pause_reg;
        go_next      = go_reg;
        ck_drv_next  = ck_drv_reg;
        lf_drv_next  = lf_drv_reg;
        in_drv_next  = in_drv_reg;
        ck_save_next = ck_save_reg;
        lf_save_next = lf_save_reg;
        safety_next  = safety_reg;
        delay_next   = delay_reg;
        tripped      = 1'b0;

        case (op_t'(operation))
            OP_TICK: begin
                if (running) begin
                    safety_next = '0;
                    case (ck_reg)
                        CK_TOP: begin
                            if (sensors.beam_blocked) begin
                                if (count_next != '1) count_next = count_next + 1'b1;
                                if (count_next == FULL) begin
                                    lf_next = LF_WAIT;
                                    go_next = 1'b0;
                                end
                                ck_next     = CK_LOWER;
                                ck_drv_next = clicker_lower_drive;
                            end else begin
                                ck_drv_next = clicker_hold_drive;
                            end
                        end
                        CK_LOWER: begin
                            if (sensors.clicker_at_bottom) begin
                                ck_next     = CK_BOTTOM;
                                ck_drv_next = '0;
                            end else begin
                                ck_drv_next = clicker_lower_drive;
                            end
                        end
                        CK_BOTTOM: begin
                            if (count_reg inside {FULL, FULL_1}) begin
                                ck_next = CK_HOLD;
                            end else begin
                                ck_next     = CK_RAISE;
                                ck_drv_next = clicker_raise_drive;
                            end
                        end
                        CK_HOLD: begin
                            if (!sensors.beam_blocked && count_reg == FULL_1) begin
                                count_next = '0;
                                ck_next    = CK_DELAY;
                                delay_next = '0;
                            end else if (lf_reg == LF_TOP && count_reg == FULL) begin
                                ck_next = CK_RAISE;
                            end else begin
                                ck_drv_next = clicker_lower_drive;
                            end
                        end
                        CK_DELAY: begin
                            if (delay_next != '1) delay_next = delay_next + 1'b1;
                            if (delay_next > restart_delay_ticks) begin
                                ck_next = CK_RAISE;
                                lf_next = LF_LOWER;
                            end
                        end
                        default: begin
                            if (sensors.clicker_at_top) begin
                                ck_next     = CK_TOP;
                                ck_drv_next = '0;
                            end else begin
                                ck_next     = CK_RAISE;
                                ck_drv_next = clicker_raise_drive;
                            end
                        end
                    endcase

                    case (lf_next)
                        LF_BOTTOM: lf_drv_next = '0;
                        LF_RAISE: begin
                            if (sensors.lifter_at_top) begin
                                lf_next     = LF_TOP;
                                lf_drv_next = '0;
                            end else begin
                                lf_drv_next = lifter_raise_drive;
                            end
                        end
                        LF_WAIT: begin
                            if (go_next) begin
                                go_next = 1'b0;
                                lf_next = LF_RAISE;
                            end
                        end
                        LF_TOP: lf_drv_next = '0;
                        default: begin
                            // any other code settles into lowering
                            lf_next = LF_LOWER;
                            if (sensors.lifter_at_bottom) begin
                                lf_next     = LF_BOTTOM;
                                lf_drv_next = '0;
                            end else begin
                                lf_drv_next = lifter_lower_drive;
                            end
                        end
                    endcase
                end else begin
                    if (safety_next != '1) safety_next = safety_next + 1'b1;
                    if (safety_next > safety_timeout_ticks) begin
                        ck_drv_next = '0;
                        lf_drv_next = '0;
                        safety_next = '0;
                        tripped     = 1'b1;
                    end
                end
            end
            OP_CLICKER_RAISE: if (!running) begin
                ck_drv_next = clicker_raise_drive;
                safety_next = '0;
            end
            OP_CLICKER_LOWER: if (!running) begin
                ck_drv_next = clicker_lower_drive;
                safety_next = '0;
            end
            OP_CLICKER_STOP: if (!running) begin
                ck_drv_next = '0;
                safety_next = '0;
            end
            OP_LIFTER_RAISE: if (!running) begin
                lf_drv_next = lifter_raise_drive;
                safety_next = '0;
            end
            OP_LIFTER_LOWER: if (!running) begin
                lf_drv_next = lifter_lower_drive;
                safety_next = '0;
            end
            OP_LIFTER_STOP: if (!running) begin
                lf_drv_next = '0;
                safety_next = '0;
            end
            OP_INTAKE_RUN: if (!running) begin
                in_drv_next = intake_run_drive;
                safety_next = '0;
            end
            OP_INTAKE_STOP: if (!running) safety_next = '0;
            OP_STOP_ALL: if (!running) begin
                ck_drv_next  = '0;
                lf_drv_next  = '0;
                ck_save_next = '0;
                lf_save_next = '0;
                safety_next  = '0;
            end
            OP_AUTO_START: if (!running) begin
                auto_next    = 1'b1;
                pause_next   = 1'b0;
                go_next      = 1'b0;
                ck_save_next = '0;
                lf_save_next = '0;
                ck_next      = CK_RAISE;
                lf_next      = LF_LOWER;
                in_drv_next  = intake_run_drive;
                count_next   = '0;
                safety_next  = '0;
            end
            OP_AUTO_STOP: if (auto_reg) begin
                auto_next   = 1'b0;
                pause_next  = 1'b0;
                go_next     = 1'b0;
                ck_drv_next = '0;
                lf_drv_next = '0;
                count_next  = '0;
                safety_next = '0;
            end
            OP_PAUSE: if (running) begin
                pause_next   = 1'b1;
                ck_save_next = ck_drv_reg;
                lf_save_next = lf_drv_reg;
                ck_drv_next  = '0;
                lf_drv_next  = '0;
                safety_next  = '0;
            end
            OP_RESUME: if (auto_reg && pause_reg) begin
                pause_next  = 1'b0;
                ck_drv_next = ck_save_reg;
                lf_drv_next = lf_save_reg;
                in_drv_next = intake_run_drive;
                safety_next = '0;
            end
            OP_GO: go_next = 1'b1;
            OP_COUNT_INC: if (count_reg < FULL) count_next = count_reg + 1'b1;
            OP_COUNT_DEC: if (count_reg != '0 && count_reg < FULL) begin
                count_next = count_reg - 1'b1;
            end
            OP_ENABLE: in_drv_next = intake_run_drive;
            OP_DISABLE: begin
                ck_drv_next = '0;
                lf_drv_next = '0;
                in_drv_next = '0;
                safety_next = '0;
                auto_next   = 1'b0;
                pause_next  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ck_reg      <= CK_TOP;
            lf_reg      <= LF_TOP;
            count_reg   <= '0;
            auto_reg    <= 1'b0;
            pause_reg   <= 1'b0;
            go_reg      <= 1'b0;
            ck_drv_reg  <= '0;
            lf_drv_reg  <= '0;
            in_drv_reg  <= '0;
            ck_save_reg <= '0;
            lf_save_reg <= '0;
            safety_reg  <= '0;
            delay_reg   <= '0;
        end else if (step) begin
            ck_reg      <= ck_next;
            lf_reg      <= lf_next;
            count_reg   <= count_next;
            auto_reg    <= auto_next;
            pause_reg   <= pause_next;
            go_reg      <= go_next;
            ck_drv_reg  <= ck_drv_next;
            lf_drv_reg  <= lf_drv_next;
            in_drv_reg  <= in_drv_next;
            ck_save_reg <= ck_save_next;
            lf_save_reg <= lf_save_next;
            safety_reg  <= safety_next;
            delay_reg   <= delay_next;
        end
    end

    assign clicker_drive_next = ck_drv_next;
    assign lifter_drive_next  = lf_drv_next;
    assign intake_drive_next  = in_drv_next;

    always_comb begin
        status_next.item_count     = count_next;
        status_next.auto_active    = auto_next;
        status_next.auto_paused    = pause_next;
        status_next.clicker_phase  = ck_next;
        status_next.lifter_phase   = lf_next;
        status_next.safety_stopped = tripped;
    end

endmodule

/* design/stack_loader_sequencer_top.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  operation, beam and four end switches
// m_        out        m_tvalid/m_tready  three drives, count, flags, phases
// cfg_      in         cfg_valid/cfg_ready register index and write data
//
// One request in, one result out; a new request can enter every cycle while results are taken.
// A request passes through the input register, then next-state logic into the result register.
// A stalled result holds in the output register while the input register takes the next
// request; the request behind it waits until the result is taken.
// aresetn is synchronous: all motors stopped, clicker top, lifter top, config at defaults.
module stack_loader_sequencer_top
    import sls_pkg::*;
#(
    parameter int DRIVE_BITS = 12,
    parameter int FULL_STACK = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // operation[4:0], beam_blocked, clicker_at_bottom, clicker_at_top,
    // lifter_at_bottom, lifter_at_top, zero pad
    input  logic [IN_BITS-1:0]           s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // clicker_drive_out, lifter_drive_out, intake_drive_out, item_count,
    // auto_active, auto_paused, clicker_phase, lifter_phase, safety_stopped, zero pad
    output logic [((3*DRIVE_BITS+STATUS_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int OUT_BITS = ((3*DRIVE_BITS+STATUS_BITS+7)/8)*8;

    logic signed [DRIVE_BITS-1:0] ck_raise, ck_lower, ck_hold, lf_raise, lf_lower, in_run;
    logic [TICK_BITS-1:0] safety_ticks, restart_ticks;

    logic                 in_valid_reg;
    logic [OP_BITS-1:0]   op_reg;
    sensors_t             sens_reg;
    logic                 out_valid_reg;
    logic signed [DRIVE_BITS-1:0] ck_out_reg, lf_out_reg, in_out_reg;
    status_t              status_reg;

    logic signed [DRIVE_BITS-1:0] ck_next, lf_next, in_next;
    status_t              status_next;
    logic                 step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    sls_cfg_regs #(
        .DRIVE_BITS(DRIVE_BITS)
    ) u_cfg (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .clicker_raise_drive  (ck_raise),
        .clicker_lower_drive  (ck_lower),
        .clicker_hold_drive   (ck_hold),
        .lifter_raise_drive   (lf_raise),
        .lifter_lower_drive   (lf_lower),
        .intake_run_drive     (in_run),
        .safety_timeout_ticks (safety_ticks),
        .restart_delay_ticks  (restart_ticks)
    );

    sls_core #(
        .DRIVE_BITS(DRIVE_BITS),
        .FULL_STACK(FULL_STACK)
    ) u_core (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .step                 (step),
        .operation            (op_reg),
        .sensors              (sens_reg),
        .clicker_raise_drive  (ck_raise),
        .clicker_lower_drive  (ck_lower),
        .clicker_hold_drive   (ck_hold),
        .lifter_raise_drive   (lf_raise),
        .lifter_lower_drive   (lf_lower),
        .intake_run_drive     (in_run),
        .safety_timeout_ticks (safety_ticks),
        .restart_delay_ticks  (restart_ticks),
        .clicker_drive_next   (ck_next),
        .lifter_drive_next    (lf_next),
        .intake_drive_next    (in_next),
        .status_next          (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tdata[OP_BITS-1:0];
            sens_reg <= s_tdata[OP_BITS+$bits(sensors_t)-1:OP_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            ck_out_reg <= ck_next;
            lf_out_reg <= lf_next;
            in_out_reg <= in_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'({status_reg, in_out_reg, lf_out_reg, ck_out_reg});

endmodule
